>>> design/arpc_pkg.sv
package arpc_pkg;

  localparam int unsigned EntriesDef = 16;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned IpW        = 32;
  localparam int unsigned MacW       = 48;
  localparam int unsigned AgeW       = 8;
  localparam logic [AgeW-1:0] TimeoutRst = 8'd15;
  localparam logic [AgeW-1:0] AgeMax     = 8'd255;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // request travelling down the cell row, collecting its result on the way
  typedef struct packed {
    logic             vld;
    logic [1:0]       op;
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  mac;
    logic             hit;
    logic [MacW-1:0]  fmac;
    logic [SlotW-1:0] slot;
    logic             stored;
  } tok_t;

endpackage

>>> design/arp_cache_table_with_aging_core.sv
// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------------
// request   | start_i / busy_o           | op_i, ip_address_i, mac_address_i
// result    | done_o (one-cycle strobe)  | hit_o, found_mac_o, slot_index_o, stored_o
// config    | timeout_we_i               | timeout_seconds_i
//
// a request is handed from cell to cell, one entry per cycle, passing the head
// register and then each cell's token register on its way to done; busy_o stays high meanwhile
// the result strobe cannot be stalled by the receiver
// reset clears all valid marks at once and sets the timeout to 15
module arp_cache_table_with_aging_core import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       op_i,
  input  logic [IpW-1:0]   ip_address_i,
  input  logic [MacW-1:0]  mac_address_i,
  input  logic             timeout_we_i,
  input  logic [AgeW-1:0]  timeout_seconds_i,
  output logic             done_o,
  output logic             hit_o,
  output logic [MacW-1:0]  found_mac_o,
  output logic [SlotW-1:0] slot_index_o,
  output logic             stored_o
);

  tok_t            chain [ENTRIES+1];
  tok_t            head_q;
  logic [ENTRIES:0] chain_vld;
  logic            busy_q, busy_d;
  logic [AgeW-1:0] timeout_q;
  logic            accept;

  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      head_q    <= '0;
      busy_q    <= 1'b0;
    end else begin
      if (timeout_we_i) begin
        timeout_q <= timeout_seconds_i;
      end
      head_q.vld <= accept;
      if (accept) begin
        head_q.op     <= op_i;
        head_q.ip     <= ip_address_i;
        head_q.mac    <= mac_address_i;
        head_q.hit    <= 1'b0;
        head_q.fmac   <= '0;
        head_q.slot   <= '0;
        head_q.stored <= 1'b0;
      end
      busy_q <= busy_d;
    end
  end

  assign chain[0] = head_q;

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (chain[ENTRIES].vld) begin
      busy_d = 1'b0;
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .timeout_i(timeout_q),
      .tok_i    (chain[g]),
      .tok_o    (chain[g+1])
    );
  end

  for (genvar g = 0; g <= ENTRIES; g++) begin : g_vld
    assign chain_vld[g] = chain[g].vld;
  end

  assign busy_o       = busy_q;
  assign done_o       = chain[ENTRIES].vld;
  assign hit_o        = chain[ENTRIES].hit;
  assign found_mac_o  = chain[ENTRIES].fmac;
  assign slot_index_o = chain[ENTRIES].slot;
  assign stored_o     = chain[ENTRIES].stored;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vld))
    else $error("more than one request in the cell row");

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q)
    else $error("result strobe outside a transfer");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("busy not raised after accept");

  a_hit_xor_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && stored_o))
    else $error("hit and stored both set");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (found_mac_o == '0))
    else $error("found mac nonzero without hit");

endmodule

>>> design/arpc_cell.sv
module arpc_cell import arpc_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [AgeW-1:0] timeout_i,
  input  tok_t            tok_i,
  output tok_t            tok_o
);

  logic            valid_q, valid_d;
  logic [IpW-1:0]  ip_q;
  logic [MacW-1:0] mac_q;
  logic [AgeW-1:0] age_q, age_d;
  logic            wr_en;
  logic [AgeW-1:0] age_inc;
  tok_t            tok_d, tok_q;

  assign age_inc = (age_q == AgeMax) ? AgeMax : age_q + 8'd1;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    age_d   = age_q;
    wr_en   = 1'b0;
    if (tok_i.vld) begin
      case (op_e'(tok_i.op))
        OP_LOOKUP: begin
          if (valid_q && (ip_q == tok_i.ip)) begin
            tok_d.hit  = 1'b1;
            tok_d.fmac = mac_q;
            tok_d.slot = SlotW'(Idx);
          end
        end
        OP_INSERT: begin
          if (!valid_q && !tok_i.stored) begin
            wr_en        = 1'b1;
            valid_d      = 1'b1;
            age_d        = '0;
            tok_d.stored = 1'b1;
            tok_d.slot   = SlotW'(Idx);
          end
        end
        OP_TICK: begin
          if (valid_q) begin
            age_d = age_inc;
            if (age_inc > timeout_i) begin
              valid_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q <= age_d;
    if (wr_en) begin
      ip_q  <= tok_i.ip;
      mac_q <= tok_i.mac;
    end
  end

  assign tok_o = tok_q;

endmodule
